### src/sddf_pkg.sv
// sddf_pkg: shared widths, constants, item types and the decimal digit step
// for the signed decimal display formatter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sddf_pkg;

    localparam int VALUE_W    = 32;
    localparam int MAG_W      = 24;
    localparam int DIGIT_W    = 4;
    localparam int PLACE_W    = 3;
    localparam int NUM_PLACES = 7;
    localparam int NUM_STAGES = NUM_PLACES - 1;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int FIFO_CW    = 2;

    localparam logic [DIGIT_W-1:0] DIGIT_BLANK = 4'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;

    localparam logic [MAG_W-1:0] POS_LIMIT = 24'd9999999;
    localparam logic [MAG_W-1:0] NEG_LIMIT = 24'd999999;

    localparam logic [MAG_W-1:0] PLACE_WEIGHT [NUM_PLACES] = '{
        24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000
    };

    typedef logic [MAG_W-1:0]   mag_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [PLACE_W-1:0] place_t;

    // classified item: saturated magnitude with sign and overflow
    typedef struct packed {
        mag_t mag;
        logic neg;
        logic ovf;
    } class_t;

    // item in flight through the digit pipeline
    typedef struct packed {
        mag_t                                 mag;
        logic                                 neg;
        logic                                 ovf;
        logic [NUM_PLACES-1:0][DIGIT_W-1:0]   dig;
    } work_t;

    // take one decimal digit off the top place; the remainder stays below the weight
    function automatic work_t digit_step(input work_t cur, input place_t place);
        work_t  nxt;
        mag_t   weight;
        mag_t   multiple;
        mag_t   taken;
        digit_t d;
        nxt      = cur;
        weight   = PLACE_WEIGHT[place];
        multiple = '0;
        taken    = '0;
        d        = '0;
        // parallel compares against the constant multiples of the weight
        for (int k = 1; k <= int'(DIGIT_MAX); k++)
        begin
            multiple = multiple + weight;
            if (cur.mag >= multiple)
            begin
                d     = DIGIT_W'(k);
                taken = multiple;
            end
        end
        nxt.mag        = cur.mag - taken;
        nxt.dig[place] = d;
        return nxt;
    endfunction

endpackage

`default_nettype wire

### src/sddf_in_if.sv
// sddf_in_if: valid/ready channel carrying one signed value per transfer.
// Depends on sddf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sddf_in_if;
    import sddf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### src/sddf_out_if.sv
// sddf_out_if: valid/ready channel carrying one formatted display result per transfer.
// Depends on sddf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sddf_out_if;
    import sddf_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit_units;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_thousands;
    logic [DIGIT_W-1:0] digit_ten_thousands;
    logic [DIGIT_W-1:0] digit_hundred_thousands;
    logic [DIGIT_W-1:0] digit_millions;
    logic [PLACE_W-1:0] minus_place;
    logic               overflow;

    modport source (
        output valid, output digit_units, output digit_tens, output digit_hundreds,
        output digit_thousands, output digit_ten_thousands,
        output digit_hundred_thousands, output digit_millions,
        output minus_place, output overflow,
        input  ready
    );
    modport sink (
        input  valid, input digit_units, input digit_tens, input digit_hundreds,
        input  digit_thousands, input digit_ten_thousands,
        input  digit_hundred_thousands, input digit_millions,
        input  minus_place, input overflow,
        output ready
    );
endinterface

`default_nettype wire

### src/sddf_front.sv
// sddf_front: accepts input values, takes the magnitude and saturates it,
// and holds the classified item for the queue. Depends on sddf_pkg, sddf_in_if.
`timescale 1ns / 1ps
`default_nettype none

module sddf_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    sddf_in_if.sink              item,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output sddf_pkg::class_t     q_item
);
    import sddf_pkg::*;

    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] abs_val;
    logic [VALUE_W-1:0] limit;
    class_t             cls_next;
    class_t             cls_reg;
    logic               vld_reg;
    logic               vld_next;
    logic               take;

    // sign, magnitude and saturation
    always_comb
    begin
        raw          = $unsigned(item.value);
        cls_next.neg = raw[VALUE_W-1];
        abs_val      = cls_next.neg ? (~raw + VALUE_W'(1)) : raw;
        limit        = cls_next.neg ? VALUE_W'(NEG_LIMIT) : VALUE_W'(POS_LIMIT);
        if (abs_val > limit)
        begin
            cls_next.mag = limit[MAG_W-1:0];
            cls_next.ovf = 1'b1;
        end
        else
        begin
            cls_next.mag = abs_val[MAG_W-1:0];
            cls_next.ovf = 1'b0;
        end
    end

    // holding register handshake
    assign item.ready = !vld_reg || q_ready;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
            vld_next = 1'b1;
        else if (q_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cls_reg <= cls_next;
    end

    assign q_valid = vld_reg;
    assign q_item  = cls_reg;

endmodule

`default_nettype wire

### src/sddf_fifo.sv
// sddf_fifo: short queue of classified items between the front and back parts.
// Depends on sddf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sddf_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire sddf_pkg::class_t push_item,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output sddf_pkg::class_t      pop_item
);
    import sddf_pkg::*;

    class_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != FIFO_CW'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + FIFO_CW'(1);
        else if (pop && !push)
            count_next = count_reg - FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### src/sddf_back.sv
// sddf_back: digit pipeline, one decimal place per stage, then blanking,
// minus placement and the output register. Depends on sddf_pkg, sddf_out_if.
`timescale 1ns / 1ps
`default_nettype none

module sddf_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire sddf_pkg::class_t pop_item,
    sddf_out_if.source            result
);
    import sddf_pkg::*;

    logic                               pipe_en;
    logic                               vld_reg [NUM_STAGES];
    work_t                              stg_reg [NUM_STAGES];
    work_t                              last;
    logic [NUM_PLACES-1:0][DIGIT_W-1:0] code_next;
    logic [NUM_PLACES-1:0][DIGIT_W-1:0] code_reg;
    place_t                             minus;
    place_t                             minus_next;
    place_t                             minus_reg;
    logic                               leading;
    logic                               ovf_reg;
    logic                               out_vld_reg;
    logic                               out_vld_next;

    // whole pipeline moves when the output register is free or being emptied
    assign pipe_en   = !out_vld_reg || result.ready;
    assign pop_ready = pipe_en;

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        work_t src;
        work_t stg_next;
        logic  src_vld;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                src.mag = pop_item.mag;
                src.neg = pop_item.neg;
                src.ovf = pop_item.ovf;
                src.dig = '0;
                src_vld = pop_valid;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                src     = stg_reg[s-1];
                src_vld = vld_reg[s-1];
            end
        end

        // one place per stage, highest place first
        always_comb
        begin
            stg_next = digit_step(src, PLACE_W'(NUM_PLACES - 1 - s));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (pipe_en)
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
                stg_reg[s] <= stg_next;
        end
    end

    // leading-zero blanking and minus placement
    always_comb
    begin
        last         = stg_reg[NUM_STAGES-1];
        code_next    = last.dig;
        code_next[0] = last.mag[DIGIT_W-1:0];
        leading      = 1'b1;
        minus        = '0;
        for (int p = NUM_PLACES - 1; p >= 1; p--)
        begin
            if (leading && last.dig[p] == '0)
            begin
                code_next[p] = DIGIT_BLANK;
                minus        = PLACE_W'(p);
            end
            else
            begin
                leading = 1'b0;
            end
        end
        minus_next = last.neg ? minus : '0;
    end

    // output register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (pipe_en)
            out_vld_next = vld_reg[NUM_STAGES-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && vld_reg[NUM_STAGES-1])
        begin
            code_reg  <= code_next;
            minus_reg <= minus_next;
            ovf_reg   <= last.ovf;
        end
    end

    assign result.valid                   = out_vld_reg;
    assign result.digit_units             = code_reg[0];
    assign result.digit_tens              = code_reg[1];
    assign result.digit_hundreds          = code_reg[2];
    assign result.digit_thousands         = code_reg[3];
    assign result.digit_ten_thousands     = code_reg[4];
    assign result.digit_hundred_thousands = code_reg[5];
    assign result.digit_millions          = code_reg[6];
    assign result.minus_place             = minus_reg;
    assign result.overflow                = ovf_reg;

endmodule

`default_nettype wire

### src/signed_decimal_display_formatter.sv
// signed_decimal_display_formatter: top level joining front, queue and digit pipeline.
// Depends on sddf_pkg, sddf_in_if, sddf_out_if, sddf_front, sddf_fifo, sddf_back.
`timescale 1ns / 1ps
`default_nettype none

// Formats one signed 32-bit value per transfer into seven display digit codes
// (10 is blank) with leading zeros blanked, the minus sign's place and an
// overflow flag; positives saturate to 9999999, negatives to -999999. A new
// value is taken every cycle while results are being taken; a result passes
// from the front register through the two-entry queue and the digit pipeline
// (one decimal place per stage) into the output register. The queue lets the
// front keep accepting for a short while when the result side stalls.
module signed_decimal_display_formatter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sddf_in_if.sink    item,
    sddf_out_if.source result
);
    import sddf_pkg::*;

    logic   front_valid;
    logic   front_ready;
    class_t front_item;
    logic   back_valid;
    logic   back_ready;
    class_t back_item;

    sddf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (front_valid),
        .q_ready (front_ready),
        .q_item  (front_item)
    );

    sddf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    sddf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .pop_item  (back_item),
        .result    (result)
    );

    // a minus sign always leaves the millions place blank
    a_minus_blanks_top: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.minus_place != '0 |-> result.digit_millions == DIGIT_BLANK)
        else $error("minus sign with millions place shown");

    // positive saturation shows all nines
    a_pos_sat_nines: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.overflow && result.minus_place == '0
        |-> result.digit_millions == DIGIT_MAX && result.digit_units == DIGIT_MAX)
        else $error("positive overflow not saturated to all nines");

    // the units place is never blank nor out of range
    a_units_digit: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.digit_units <= DIGIT_MAX)
        else $error("units place out of range");

endmodule

`default_nettype wire

### bench/tb_top.sv
// tb_top: self-checking bench for the signed decimal display formatter.
// Depends on sddf_pkg, sddf_in_if, sddf_out_if and signed_decimal_display_formatter.
`timescale 1ns / 1ps

// one formatted display result, as seen on the result channel
typedef struct packed {
    sddf_pkg::digit_t units;
    sddf_pkg::digit_t tens;
    sddf_pkg::digit_t hundreds;
    sddf_pkg::digit_t thousands;
    sddf_pkg::digit_t ten_thousands;
    sddf_pkg::digit_t hundred_thousands;
    sddf_pkg::digit_t millions;
    sddf_pkg::place_t minus_place;
    logic             overflow;
} display_code_t;

// predicts the display codes of each accepted value and checks results in order
class display_code_tracker;
    localparam logic [31:0] POS_MAX   = 32'd9999999;
    localparam logic [31:0] NEG_MAX   = 32'd999999;
    localparam logic [3:0]  BLANK     = 4'd10;
    localparam int          TOP_PLACE = 6;

    display_code_t pending_codes[$];
    int unsigned   errors;
    int unsigned   values_noted;
    int unsigned   negatives;
    int unsigned   saturated;
    int unsigned   results_checked;

    function new();
        errors          = 0;
        values_noted    = 0;
        negatives       = 0;
        saturated       = 0;
        results_checked = 0;
    endfunction

    // decimal split with saturation, leading-zero blanking and minus placement
    function display_code_t format_for_display(input logic signed [31:0] v);
        display_code_t r;
        logic [31:0]   mag;
        logic [31:0]   weight;
        logic [31:0]   d;
        logic [3:0]    code [7];
        logic [2:0]    minus;
        bit            neg;
        bit            leading;
        bit            ovf;
        neg     = v[31];
        ovf     = 1'b0;
        minus   = '0;
        leading = 1'b1;
        mag     = neg ? (~v + 32'd1) : v;
        if (neg && mag > NEG_MAX)
        begin
            mag = NEG_MAX;
            ovf = 1'b1;
        end
        else if (!neg && mag > POS_MAX)
        begin
            mag = POS_MAX;
            ovf = 1'b1;
        end
        weight = 32'd1000000;
        for (int p = TOP_PLACE; p >= 0; p--)
        begin
            d      = mag / weight;
            mag    = mag % weight;
            weight = weight / 32'd10;
            if (p > 0 && leading && d == 0)
            begin
                code[p] = BLANK;
                minus   = 3'(p);
            end
            else
            begin
                code[p] = d[3:0];
                leading = 1'b0;
            end
        end
        r.units             = code[0];
        r.tens              = code[1];
        r.hundreds          = code[2];
        r.thousands         = code[3];
        r.ten_thousands     = code[4];
        r.hundred_thousands = code[5];
        r.millions          = code[6];
        r.minus_place       = neg ? minus : 3'd0;
        r.overflow          = ovf;
        return r;
    endfunction

    function void note_value(input logic signed [31:0] v);
        display_code_t e;
        e = format_for_display(v);
        pending_codes.push_back(e);
        values_noted++;
        if (v[31])
            negatives++;
        if (e.overflow)
            saturated++;
    endfunction

    function void compare_field(input string name, input int unsigned exp_val,
                                input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
        end
    endfunction

    function void check_result(input display_code_t act);
        display_code_t e;
        if (pending_codes.size() == 0)
        begin
            $error("result transfer with no value outstanding");
            errors++;
            return;
        end
        e = pending_codes.pop_front();
        results_checked++;
        compare_field("digit_units", e.units, act.units);
        compare_field("digit_tens", e.tens, act.tens);
        compare_field("digit_hundreds", e.hundreds, act.hundreds);
        compare_field("digit_thousands", e.thousands, act.thousands);
        compare_field("digit_ten_thousands", e.ten_thousands, act.ten_thousands);
        compare_field("digit_hundred_thousands", e.hundred_thousands,
                      act.hundred_thousands);
        compare_field("digit_millions", e.millions, act.millions);
        compare_field("minus_place", e.minus_place, act.minus_place);
        compare_field("overflow", e.overflow, act.overflow);
    endfunction

    function int unsigned outstanding();
        return pending_codes.size();
    endfunction
endclass

module tb_top;
    localparam int          RANDOM_VALUES   = 1526;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          IDLE_PERCENT    = 25;
    localparam int          CALM_FIRST      = 600;
    localparam int          CALM_LAST       = 900;
    localparam int unsigned HOLD_AT_RESULT  = 300;
    localparam int unsigned HOLD_CYCLES     = 200;

    localparam logic signed [31:0] CORNER_VALUES [24] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
        -32'sd99999, 32'sd100000, -32'sd100000, -32'sd100001, 32'sd1000000,
        32'sd1000001, 32'sd1234567, 32'sd7000000, 32'sd10203, -32'sd5,
        32'sd9999999, 32'sd10000000, -32'sd999999, -32'sd1000000,
        32'sh7FFF_FFFF, 32'sh8000_0000
    };

    logic        clk;
    logic        rst_n;
    int unsigned cycle_count;

    sddf_in_if  in_if ();
    sddf_out_if out_if ();

    display_code_tracker tracker;

    signed_decimal_display_formatter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_if),
        .result (out_if)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top: timed out with %0d results outstanding", tracker.outstanding());
        $display("tb_top: FAIL");
        $finish;
    end

    // offer one value, idling beforehand at random, and wait for its transfer
    task automatic offer_value(input logic signed [31:0] v, input bit may_idle);
        while (may_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do
            @(posedge clk);
        while (!in_if.ready);
        tracker.note_value(v);
    endtask

    // random value shaped towards saturation edges and blanking patterns
    function automatic logic signed [31:0] pick_value();
        int          mag;
        int          ndig;
        logic [31:0] raw;
        mag = 0;
        raw = '0;
        case ($urandom_range(0, 7))
            0: raw = $urandom;
            1: raw = $urandom_range(0, 9999999);
            2: raw = -$urandom_range(0, 999999);
            3: raw = 32'd9999989 + $urandom_range(0, 20);
            4: raw = -(32'd999989 + $urandom_range(0, 20));
            5:
            begin
                ndig = $urandom_range(1, 7);
                for (int i = 0; i < ndig; i++)
                    mag = mag * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 9));
                raw = $urandom_range(0, 1) ? -mag : mag;
            end
            6: raw = $urandom_range(0, 1) ? -$urandom_range(0, 99) : $urandom_range(0, 99);
            default:
            begin
                mag = $urandom_range(1, 9);
                ndig = $urandom_range(0, 7);
                for (int i = 0; i < ndig; i++)
                    mag = mag * 10;
                raw = $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
        return raw;
    endfunction

    // result side: check each transfer, random back-pressure outside a calm window and one long hold-off
    initial
    begin : result_sink
        display_code_t act;
        int unsigned   hold_left;
        bit            held;
        hold_left = 0;
        held      = 1'b0;
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready)
            begin
                act.units             = out_if.digit_units;
                act.tens              = out_if.digit_tens;
                act.hundreds          = out_if.digit_hundreds;
                act.thousands         = out_if.digit_thousands;
                act.ten_thousands     = out_if.digit_ten_thousands;
                act.hundred_thousands = out_if.digit_hundred_thousands;
                act.millions          = out_if.digit_millions;
                act.minus_place       = out_if.minus_place;
                act.overflow          = out_if.overflow;
                tracker.check_result(act);
            end
            if (hold_left > 0)
            begin
                out_if.ready <= 1'b0;
                hold_left--;
            end
            else if (!held && tracker.results_checked == HOLD_AT_RESULT)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_if.ready <= 1'b0;
            end
            else if (tracker.results_checked >= CALM_FIRST &&
                     tracker.results_checked < CALM_LAST)
                out_if.ready <= 1'b1;
            else
                out_if.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // reset, directed corners, random values, drain and verdict
    initial
    begin : value_source
        tracker = new();
        cycle_count = 0;
        rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CORNER_VALUES[i])
            offer_value(CORNER_VALUES[i], 1'b1);
        for (int i = 0; i < RANDOM_VALUES; i++)
            offer_value(pick_value(), !(i >= CALM_FIRST && i < CALM_LAST));
        in_if.valid <= 1'b0;

        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d values formatted, %0d negative, %0d saturated",
                 tracker.values_noted, tracker.negatives, tracker.saturated);
        $display("tb_top: %0d results checked, one output hold-off of %0d cycles",
                 tracker.results_checked, HOLD_CYCLES);
        if (tracker.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
